// File: hw/rtl/dcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcw_pkg
// Shared types, constants and digit helpers for the drawing command parser.
// ----------------------------------------------------------------------------
package dcw_pkg;

   localparam int WINDOW_LEN   = 14;
   localparam int POINT_OFFSET = 6;
   localparam int CHAR_W       = 8;
   localparam int COORD_W      = 10;
   localparam int KIND_W       = 2;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 10;

   // Command kinds as reported on the result channel.
   localparam logic [KIND_W-1:0] KIND_POINT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ELLIPSE = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_X_LIMIT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_LIMIT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_CODE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_CODE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELLIPSE_CODE = 3'd4;

   localparam logic [COORD_W-1:0] X_LIMIT_RESET      = 10'd999;
   localparam logic [COORD_W-1:0] Y_LIMIT_RESET      = 10'd999;
   localparam logic [CHAR_W-1:0]  POINT_CODE_RESET   = 8'd80;
   localparam logic [CHAR_W-1:0]  LINE_CODE_RESET    = 8'd76;
   localparam logic [CHAR_W-1:0]  ELLIPSE_CODE_RESET = 8'd69;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] ASCII_TWO  = 8'h32;

   // Slot 0 is the oldest character, slot WINDOW_LEN-1 the newest.
   typedef logic [WINDOW_LEN-1:0][CHAR_W-1:0] window_type;
   typedef logic [WINDOW_LEN-2:0][CHAR_W-1:0] history_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_limit;
      logic [COORD_W-1:0] y_limit;
      logic [CHAR_W-1:0]  point_code;
      logic [CHAR_W-1:0]  line_code;
      logic [CHAR_W-1:0]  ellipse_code;
   } csr_type;

   typedef struct packed {
      logic               valid_res;
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x_first;
      logic [COORD_W-1:0] y_first;
      logic [COORD_W-1:0] x_second;
      logic [COORD_W-1:0] y_second;
      logic [MODE_W-1:0]  draw_mode;
   } result_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
   endfunction

   // Value of a three digit field; only meaningful when all three are digits.
   function automatic logic [COORD_W-1:0] three_value(input logic [CHAR_W-1:0] a,
                                                      input logic [CHAR_W-1:0] b,
                                                      input logic [CHAR_W-1:0] c);
      logic [COORD_W-1:0] da;
      logic [COORD_W-1:0] db;
      logic [COORD_W-1:0] dc;
      da = COORD_W'(a[3:0]);
      db = COORD_W'(b[3:0]);
      dc = COORD_W'(c[3:0]);
      return COORD_W'(da * 10'd100 + db * 10'd10 + dc);
   endfunction

   function automatic logic three_ok(input logic [CHAR_W-1:0] a,
                                     input logic [CHAR_W-1:0] b,
                                     input logic [CHAR_W-1:0] c);
      return is_digit(a) && is_digit(b) && is_digit(c);
   endfunction

   // The mode character must be '0', '1' or '2'.
   function automatic logic mode_ok(input logic [CHAR_W-1:0] c);
      return (c >= ASCII_ZERO) && (c <= ASCII_TWO);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dcw_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcw_csr
// Configuration registers: coordinate limits and command codes.
// ----------------------------------------------------------------------------
module dcw_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [dcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dcw_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output dcw_pkg::csr_type                     csr_out
);

   dcw_pkg::csr_type csr_ff;
   dcw_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dcw_pkg::CSR_X_LIMIT:      csr_in.x_limit = csr_wr_data;
            dcw_pkg::CSR_Y_LIMIT:      csr_in.y_limit = csr_wr_data;
            dcw_pkg::CSR_POINT_CODE:   csr_in.point_code = csr_wr_data[dcw_pkg::CHAR_W-1:0];
            dcw_pkg::CSR_LINE_CODE:    csr_in.line_code = csr_wr_data[dcw_pkg::CHAR_W-1:0];
            dcw_pkg::CSR_ELLIPSE_CODE: begin
               csr_in.ellipse_code = csr_wr_data[dcw_pkg::CHAR_W-1:0];
            end
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.x_limit      <= dcw_pkg::X_LIMIT_RESET;
         csr_ff.y_limit      <= dcw_pkg::Y_LIMIT_RESET;
         csr_ff.point_code   <= dcw_pkg::POINT_CODE_RESET;
         csr_ff.line_code    <= dcw_pkg::LINE_CODE_RESET;
         csr_ff.ellipse_code <= dcw_pkg::ELLIPSE_CODE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_out = csr_ff;

endmodule
`default_nettype wire

// File: hw/rtl/dcw_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcw_window
// Character history shift line and the input register holding one window.
// ----------------------------------------------------------------------------
module dcw_window (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [dcw_pkg::CHAR_W-1:0] in_char,
   input  wire logic                       advance,
   output logic                            win_valid,
   output dcw_pkg::window_type             window
);

   dcw_pkg::history_type hist_ff;
   dcw_pkg::history_type hist_in;
   dcw_pkg::window_type  win_ff;
   dcw_pkg::window_type  win_in;
   logic                 valid_ff;
   logic                 valid_in;

   // The new character lands in the newest slot; the history then drops
   // its oldest byte.
   always_comb begin
      win_in   = {in_char, hist_ff};
      hist_in  = accept ? win_in[dcw_pkg::WINDOW_LEN-1:1] : hist_ff;
      valid_in = accept | (valid_ff & ~advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         hist_ff  <= hist_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   assign win_valid = valid_ff;
   assign window    = win_ff;

endmodule
`default_nettype wire

// File: hw/rtl/dcw_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcw_check
// Decodes the window and checks it for a point, line or ellipse command.
// ----------------------------------------------------------------------------
module dcw_check (
   input  wire dcw_pkg::window_type  window,
   input  wire dcw_pkg::csr_type     csr,
   output dcw_pkg::result_type       result
);

   localparam int PO = dcw_pkg::POINT_OFFSET;

   logic [dcw_pkg::COORD_W-1:0] px;
   logic [dcw_pkg::COORD_W-1:0] py;
   logic                        p_ok;
   logic [dcw_pkg::COORD_W-1:0] lx1;
   logic [dcw_pkg::COORD_W-1:0] ly1;
   logic [dcw_pkg::COORD_W-1:0] lx2;
   logic [dcw_pkg::COORD_W-1:0] ly2;
   logic                        l_digits;
   logic                        l_ok;
   logic                        is_point;
   logic                        is_line;
   logic                        is_ell;
   logic [dcw_pkg::MODE_W-1:0]  p_mode;
   logic [dcw_pkg::MODE_W-1:0]  l_mode;

   always_comb begin
      px = dcw_pkg::three_value(window[PO+1], window[PO+2], window[PO+3]);
      py = dcw_pkg::three_value(window[PO+4], window[PO+5], window[PO+6]);
      p_mode = window[PO+7][dcw_pkg::MODE_W-1:0];
      p_ok = dcw_pkg::three_ok(window[PO+1], window[PO+2], window[PO+3])
           && dcw_pkg::three_ok(window[PO+4], window[PO+5], window[PO+6])
           && dcw_pkg::mode_ok(window[PO+7])
           && (px <= csr.x_limit) && (py <= csr.y_limit);

      lx1 = dcw_pkg::three_value(window[1], window[2], window[3]);
      ly1 = dcw_pkg::three_value(window[4], window[5], window[6]);
      lx2 = dcw_pkg::three_value(window[7], window[8], window[9]);
      ly2 = dcw_pkg::three_value(window[10], window[11], window[12]);
      l_mode = window[13][dcw_pkg::MODE_W-1:0];
      l_digits = dcw_pkg::three_ok(window[1], window[2], window[3])
               && dcw_pkg::three_ok(window[4], window[5], window[6])
               && dcw_pkg::three_ok(window[7], window[8], window[9])
               && dcw_pkg::three_ok(window[10], window[11], window[12])
               && dcw_pkg::mode_ok(window[13]);
      l_ok = l_digits && (lx1 <= csr.x_limit) && (ly1 <= csr.y_limit)
           && (lx2 <= csr.x_limit) && (ly2 <= csr.y_limit);

      // A point code in its slot hides any command at slot 0, and a line
      // code wins over an equal ellipse code.
      is_point = (window[PO] == csr.point_code);
      is_line  = !is_point && (window[0] == csr.line_code);
      is_ell   = !is_point && !is_line && (window[0] == csr.ellipse_code);

      result = '0;
      if (is_point && p_ok) begin
         result.valid_res = 1'b1;
         result.kind      = dcw_pkg::KIND_POINT;
         result.x_first   = px;
         result.y_first   = py;
         result.draw_mode = p_mode;
      end else if ((is_line && l_ok) ||
                   (is_ell && l_ok && (lx2 != '0) && (ly2 != '0))) begin
         result.valid_res = 1'b1;
         result.kind      = is_line ? dcw_pkg::KIND_LINE : dcw_pkg::KIND_ELLIPSE;
         result.x_first   = lx1;
         result.y_first   = ly1;
         result.x_second  = lx2;
         result.y_second  = ly2;
         result.draw_mode = l_mode;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/drawing_command_window_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drawing_command_window_parser
// Sliding window parser for point, line and ellipse drawing commands.
// ----------------------------------------------------------------------------
//   channel   direction   handshake            word
//   req_      in          req_valid/req_stall  one character byte
//   rsp_      out         rsp_valid/rsp_stall  valid flag and decoded fields
//   csr_      in          csr_wr_en            index and data, no read-back
//
// One character per cycle while req_stall is low, through the window
// register, then the command check into the result register.
// Reset clears the character history to zeros and empties both stages.
// A stalled result is held; the window stage still takes one more character,
// and req_stall rises only when both stages are full and rsp_stall is high.
// ----------------------------------------------------------------------------
module drawing_command_window_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [dcw_pkg::CHAR_W-1:0]      req_in_char,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid_res,
   output logic [dcw_pkg::KIND_W-1:0]           rsp_kind,
   output logic [dcw_pkg::COORD_W-1:0]          rsp_x_first,
   output logic [dcw_pkg::COORD_W-1:0]          rsp_y_first,
   output logic [dcw_pkg::COORD_W-1:0]          rsp_x_second,
   output logic [dcw_pkg::COORD_W-1:0]          rsp_y_second,
   output logic [dcw_pkg::MODE_W-1:0]           rsp_draw_mode,
   input  wire logic                            csr_wr_en,
   input  wire logic [dcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dcw_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   dcw_pkg::csr_type    csr;
   dcw_pkg::window_type window;
   dcw_pkg::result_type check_result;
   dcw_pkg::result_type res_ff;
   logic                win_valid;
   logic                advance;
   logic                accept;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   assign advance   = win_valid && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = win_valid && !advance;
   assign accept    = req_valid && !req_stall;

   dcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .csr_out     (csr)
   );

   dcw_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_char   (req_in_char),
      .advance   (advance),
      .win_valid (win_valid),
      .window    (window)
   );

   dcw_check u_check (
      .window (window),
      .csr    (csr),
      .result (check_result)
   );

   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= check_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = res_ff.valid_res;
   assign rsp_kind      = res_ff.kind;
   assign rsp_x_first   = res_ff.x_first;
   assign rsp_y_first   = res_ff.y_first;
   assign rsp_x_second  = res_ff.x_second;
   assign rsp_y_second  = res_ff.y_second;
   assign rsp_draw_mode = res_ff.draw_mode;

endmodule
`default_nettype wire
